FILE: hw/rtl/text_console_writer_core_macros.svh
// Assertion macros used by the checker of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("text console writer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("text console writer check failed");

`endif

FILE: hw/rtl/tcw_pkg.sv
// Package with the types and constants of the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 11;
  localparam int CCOL_W = 7;
  localparam int CROW_W = 5;
  localparam int CELL_W = 2 * CHAR_W;

  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    CMD_NOP   = 3'd0,
    CMD_PUT   = 3'd1,
    CMD_LF    = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [CHAR_W-1:0]  char_code;
    logic [IDX_W-1:0]   cell_index;
  } cmd_t;

endpackage

FILE: hw/rtl/tcw_in_if.sv
// Input channel interface of the text console writer.
`timescale 1ns / 1ps

interface tcw_in_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::OP_W-1:0]      operation;
  logic [tcw_pkg::CHAR_W-1:0]    char_code;
  logic [tcw_pkg::IDX_W-1:0]     cell_index;

  modport source (output valid, output operation, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input operation, input char_code, input cell_index,
                output ready);
endinterface

FILE: hw/rtl/tcw_out_if.sv
// Result channel interface of the text console writer.
`timescale 1ns / 1ps

interface tcw_out_if;
  logic                          valid;
  logic                          ready;
  logic [tcw_pkg::CHAR_W-1:0]    cell_char;
  logic [tcw_pkg::CHAR_W-1:0]    cell_attr;
  logic [tcw_pkg::CCOL_W-1:0]    cursor_col;
  logic [tcw_pkg::CROW_W-1:0]    cursor_row;

  modport source (output valid, output cell_char, output cell_attr, output cursor_col,
                  output cursor_row, input ready);
  modport sink (input valid, input cell_char, input cell_attr, input cursor_col,
                input cursor_row, output ready);
endinterface

FILE: hw/rtl/text_console_writer_core.sv
// A word passes the command queue, the idle and emit states and the result register.
// The back end takes a new command only after its execute and result steps for the last one.
// A newline carried out on the last row adds the line copy and redraw.
// A clear writes zeros to every cell before its result word.
// After reset a clearing pass over every cell runs with in_ch.ready low.
// The attribute register resets to 7 and is written whenever cfg_we is high.
`timescale 1ns / 1ps

module text_console_writer_core #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  tcw_in_if.sink                        in_ch,
  tcw_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_wdata
);

  logic          push, pop, q_full, q_empty, init_busy;
  tcw_pkg::cmd_t push_cmd, head;

  tcw_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  tcw_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  tcw_back #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .q_empty   (q_empty),
    .pop       (pop),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/tcw_front.sv
// Front end: accepts input words and classifies them into commands.
`timescale 1ns / 1ps

module tcw_front #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  tcw_in_if.sink          in_ch,
  input  logic            q_full,
  input  logic            init_busy,
  output logic            push,
  output tcw_pkg::cmd_t   push_cmd
);

  localparam int TOTAL = ROWS * COLS;

  tcw_pkg::cmd_kind_t kind;

  always_comb begin
    kind = tcw_pkg::CMD_NOP;
    case (in_ch.operation)
      tcw_pkg::OP_PUT: begin
        if (in_ch.char_code == tcw_pkg::CH_LF) begin
          kind = tcw_pkg::CMD_LF;
        end else if (in_ch.char_code != tcw_pkg::CH_CR) begin
          kind = tcw_pkg::CMD_PUT;
        end
      end
      tcw_pkg::OP_READ: begin
        if (32'(in_ch.cell_index) < 32'(TOTAL)) begin
          kind = tcw_pkg::CMD_READ;
        end
      end
      tcw_pkg::OP_CLEAR: begin
        kind = tcw_pkg::CMD_CLEAR;
      end
      default: begin
        kind = tcw_pkg::CMD_NOP;
      end
    endcase
  end

  assign in_ch.ready         = !q_full && !init_busy;
  assign push                = in_ch.valid && in_ch.ready;
  assign push_cmd.kind       = kind;
  assign push_cmd.char_code  = in_ch.char_code;
  assign push_cmd.cell_index = in_ch.cell_index;

endmodule

FILE: hw/rtl/tcw_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module tcw_cmd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tcw_pkg::cmd_t   push_cmd,
  input  logic            pop,
  output tcw_pkg::cmd_t   head,
  output logic            full,
  output logic            empty
);

  tcw_pkg::cmd_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: hw/rtl/tcw_back.sv
// Back end: cursor state, cell store, scroll and clear sweeps, result register.
`timescale 1ns / 1ps

module tcw_back #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_wdata,
  input  tcw_pkg::cmd_t                 head,
  input  logic                          q_empty,
  output logic                          pop,
  output logic                          init_busy,
  tcw_out_if.source                     out_ch
);

  localparam int TOTAL = ROWS * COLS;
  localparam int NSRC  = (ROWS - 1) * COLS;
  localparam int AW    = $clog2(TOTAL);
  localparam int CW    = $clog2(COLS + 1);
  localparam int RW    = $clog2(ROWS);
  localparam int CNTW  = $clog2(TOTAL + 1);

  localparam logic [CNTW-1:0] CNT_TOTAL = CNTW'(TOTAL);
  localparam logic [CNTW-1:0] CNT_LAST  = CNTW'(TOTAL - 1);
  localparam logic [CNTW-1:0] CNT_NSRC  = CNTW'(NSRC);
  localparam logic [RW-1:0]   ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0]   COL_END   = CW'(COLS);

  typedef enum logic [5:0] {
    S_INIT   = 6'b000001,
    S_WIPE   = 6'b000010,
    S_IDLE   = 6'b000100,
    S_SCROLL = 6'b001000,
    S_PUT    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CW-1:0]                col_r, col_nxt;
  logic [RW-1:0]                row_r, row_nxt;
  logic                         pend_r, pend_nxt;
  logic                         wrap_r, wrap_nxt;
  logic [CNTW-1:0]              cnt_r, cnt_nxt;
  logic                         res_read_r, res_read_nxt;
  tcw_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [tcw_pkg::CHAR_W-1:0]   attr_r;

  logic                         out_valid_r;
  logic [tcw_pkg::CHAR_W-1:0]   out_char_r, out_attr_r;
  logic [tcw_pkg::CCOL_W-1:0]   out_col_r;
  logic [tcw_pkg::CROW_W-1:0]   out_row_r;
  logic                         out_load;

  tcw_pkg::cmd_t                cur;
  logic [CW-1:0]                p_col;
  logic [RW-1:0]                p_row;
  logic                         p_pend, p_wrap, p_we, p_done;
  logic [AW-1:0]                p_addr;
  logic [tcw_pkg::CELL_W-1:0]   p_wdata;

  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [tcw_pkg::CELL_W-1:0]   wr_data, rd_data;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (TOTAL)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cur       = (state_r == S_IDLE) ? head : cmd_r;
  assign p_wdata   = {attr_r, cur.char_code};
  assign init_busy = (state_r == S_INIT);

  // A pending newline is carried out first, then the character or newline itself; a newline after a wrap is swallowed.
  always_comb begin
    p_col  = col_r;
    p_row  = row_r;
    p_pend = pend_r;
    p_wrap = wrap_r;
    p_we   = 1'b0;
    p_done = 1'b0;
    p_addr = '0;
    if (pend_r) begin
      p_col  = '0;
      p_row  = row_r + RW'(1);
      p_pend = 1'b0;
      if (cur.kind == tcw_pkg::CMD_LF && wrap_r) begin
        p_done = 1'b1;
      end
    end
    if (!p_done) begin
      if (cur.kind == tcw_pkg::CMD_LF) begin
        p_pend = 1'b1;
        p_wrap = 1'b0;
      end else begin
        p_we   = 1'b1;
        p_addr = AW'(p_row) * AW'(COLS) + AW'(p_col);
        p_col  = p_col + CW'(1);
        if (p_col == COL_END) begin
          p_pend = 1'b1;
          p_wrap = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    pend_nxt     = pend_r;
    wrap_nxt     = wrap_r;
    cnt_nxt      = cnt_r;
    cmd_nxt      = cmd_r;
    res_read_nxt = res_read_r;
    pop          = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;
    rd_en        = 1'b0;
    rd_addr      = '0;
    out_load     = 1'b0;
    case (state_r)
      S_INIT, S_WIPE: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cnt_r);
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNT_LAST) begin
          cnt_nxt      = '0;
          res_read_nxt = 1'b0;
          state_nxt    = (state_r == S_INIT) ? S_IDLE : S_EMIT;
        end
      end
      S_IDLE: begin
        if (!q_empty) begin
          pop          = 1'b1;
          res_read_nxt = 1'b0;
          state_nxt    = S_EMIT;
          case (head.kind)
            tcw_pkg::CMD_READ: begin
              rd_en        = 1'b1;
              rd_addr      = AW'(head.cell_index);
              res_read_nxt = 1'b1;
            end
            tcw_pkg::CMD_CLEAR: begin
              col_nxt   = '0;
              row_nxt   = '0;
              pend_nxt  = 1'b0;
              wrap_nxt  = 1'b0;
              cnt_nxt   = '0;
              state_nxt = S_WIPE;
            end
            tcw_pkg::CMD_PUT, tcw_pkg::CMD_LF: begin
              if (pend_r && row_r == ROW_LAST) begin
                col_nxt  = '0;
                pend_nxt = 1'b0;
                cmd_nxt  = head;
                if (head.kind == tcw_pkg::CMD_LF && wrap_r) begin
                  cmd_nxt.kind = tcw_pkg::CMD_NOP;
                end
                cnt_nxt   = '0;
                state_nxt = S_SCROLL;
              end else begin
                col_nxt  = p_col;
                row_nxt  = p_row;
                pend_nxt = p_pend;
                wrap_nxt = p_wrap;
                wr_en    = p_we;
                wr_addr  = p_addr;
                wr_data  = p_wdata;
              end
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_SCROLL: begin
        // Read one line ahead, write the word read in the previous cycle.
        if (cnt_r < CNT_NSRC) begin
          rd_en   = 1'b1;
          rd_addr = AW'(cnt_r + CNTW'(COLS));
        end
        if (cnt_r != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cnt_r - CNTW'(1));
          wr_data = (cnt_r <= CNT_NSRC) ? rd_data : '0;
        end
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNT_TOTAL) begin
          cnt_nxt   = '0;
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        state_nxt = S_EMIT;
        if (cmd_r.kind != tcw_pkg::CMD_NOP) begin
          col_nxt  = p_col;
          row_nxt  = p_row;
          pend_nxt = p_pend;
          wrap_nxt = p_wrap;
          wr_en    = p_we;
          wr_addr  = p_addr;
          wr_data  = p_wdata;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      pend_r      <= 1'b0;
      wrap_r      <= 1'b0;
      cnt_r       <= '0;
      res_read_r  <= 1'b0;
      attr_r      <= tcw_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pend_r     <= pend_nxt;
      wrap_r     <= wrap_nxt;
      cnt_r      <= cnt_nxt;
      res_read_r <= res_read_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (out_load) begin
      out_char_r <= res_read_r ? rd_data[tcw_pkg::CHAR_W-1:0] : '0;
      out_attr_r <= res_read_r ? rd_data[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W] : '0;
      out_col_r  <= tcw_pkg::CCOL_W'(col_r);
      out_row_r  <= tcw_pkg::CROW_W'(row_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_char  = out_char_r;
  assign out_ch.cell_attr  = out_attr_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.cursor_row = out_row_r;

endmodule

FILE: hw/rtl/tcw_checker.sv
// Port-level checker of the text console writer and its bind.
`timescale 1ns / 1ps
`include "text_console_writer_core_macros.svh"

module tcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tcw_pkg::CHAR_W-1:0]    out_cell_char,
  input logic [tcw_pkg::CHAR_W-1:0]    out_cell_attr,
  input logic [tcw_pkg::CCOL_W-1:0]    out_cursor_col,
  input logic [tcw_pkg::CROW_W-1:0]    out_cursor_row
);

  // A stalled result word stays valid and unchanged.
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_cell_char) && $stable(out_cell_attr) && $stable(out_cursor_col) && $stable(out_cursor_row))

  // The reported cursor column never exceeds COLS and the row lies within the screen.
  `TCW_ASSERT_IMPL(a_cursor_range, clk, rst_n, out_valid, (32'(out_cursor_col) <= 32'(COLS)) && (32'(out_cursor_row) < 32'(ROWS)))

  // The store is being cleared right after reset, so no word is taken.
  `TCW_ASSERT_IMPL(a_init_stall, clk, rst_n, $past(!rst_n), !in_ready && !out_valid)

endmodule

bind text_console_writer_core tcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_cell_char  (out_ch.cell_char),
  .out_cell_attr  (out_ch.cell_attr),
  .out_cursor_col (out_ch.cursor_col),
  .out_cursor_row (out_ch.cursor_row)
);

FILE: tb/tb_text_console_writer_core.sv
// Self-checking testbench of the text console writer core with a shadow screen and random traffic.
`timescale 1ns / 1ps

module tb_text_console_writer_core;

  localparam int OP_W   = tcw_pkg::OP_W;
  localparam int CHAR_W = tcw_pkg::CHAR_W;
  localparam int IDX_W  = tcw_pkg::IDX_W;
  localparam int CCOL_W = tcw_pkg::CCOL_W;
  localparam int CROW_W = tcw_pkg::CROW_W;
  localparam logic [OP_W-1:0] OP_PUT   = tcw_pkg::OP_PUT;
  localparam logic [OP_W-1:0] OP_READ  = tcw_pkg::OP_READ;
  localparam logic [OP_W-1:0] OP_CLEAR = tcw_pkg::OP_CLEAR;
  localparam logic [CHAR_W-1:0] CH_CR      = tcw_pkg::CH_CR;
  localparam logic [CHAR_W-1:0] CH_LF      = tcw_pkg::CH_LF;
  localparam logic [CHAR_W-1:0] ATTR_RESET = tcw_pkg::ATTR_RESET;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = COLS * ROWS;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } console_word_t;

  typedef struct {
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
    logic [CCOL_W-1:0] cursor_col;
    logic [CROW_W-1:0] cursor_row;
  } console_view_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;

  tcw_in_if in_bus ();
  tcw_out_if out_bus ();

  text_console_writer_core #(.COLS(COLS), .ROWS(ROWS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  console_word_t pending_words[$];
  console_view_t expected_views[$];
  int words_queued = 0;
  int views_seen = 0;
  int mismatch_count = 0;
  bit calm = 1'b0;
  int src_gap = 0;
  int sink_stall = 0;

  logic [2*CHAR_W-1:0] shadow_cells [CELLS] = '{default: '0};
  int cur_col = 0;
  int cur_row = 0;
  bit lf_due = 1'b0;
  bit wrapped = 1'b0;
  logic [CHAR_W-1:0] text_attr = ATTR_RESET;

  task automatic predict_console(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                 input logic [IDX_W-1:0] idx);
    console_view_t v;
    bit skip;
    v.cell_char = '0;
    v.cell_attr = '0;
    skip = 1'b0;
    case (op)
      OP_PUT: begin
        if (ch != CH_CR) begin
          if (lf_due) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS) begin
              for (int i = 0; i < (ROWS - 1) * COLS; i++)
                shadow_cells[i] = shadow_cells[i + COLS];
              for (int i = (ROWS - 1) * COLS; i < CELLS; i++) shadow_cells[i] = '0;
              cur_row = ROWS - 1;
            end
            lf_due = 1'b0;
            skip = (ch == CH_LF) && wrapped;
          end
          if (!skip) begin
            if (ch == CH_LF) begin
              lf_due = 1'b1;
              wrapped = 1'b0;
            end else begin
              shadow_cells[cur_row * COLS + cur_col] = {text_attr, ch};
              cur_col++;
              if (cur_col >= COLS) begin
                lf_due = 1'b1;
                wrapped = 1'b1;
              end
            end
          end
        end
      end
      OP_READ: begin
        if (idx < CELLS) begin
          v.cell_char = shadow_cells[idx][CHAR_W-1:0];
          v.cell_attr = shadow_cells[idx][2*CHAR_W-1:CHAR_W];
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) shadow_cells[i] = '0;
        cur_col = 0;
        cur_row = 0;
        lf_due = 1'b0;
        wrapped = 1'b0;
      end
      default: ;
    endcase
    v.cursor_col = cur_col[CCOL_W-1:0];
    v.cursor_row = cur_row[CROW_W-1:0];
    expected_views.push_back(v);
  endtask

  // Input side: presents queued words and predicts each one as it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        predict_console(in_bus.operation, in_bus.char_code, in_bus.cell_index);
      if (!in_bus.valid || in_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_bus.valid <= 1'b0;
        end else if (!calm && $urandom_range(99, 0) < 10) begin
          src_gap = $urandom_range(12, 0);
          in_bus.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          console_word_t w;
          w = pending_words.pop_front();
          in_bus.operation <= w.op;
          in_bus.char_code <= w.ch;
          in_bus.cell_index <= w.idx;
          in_bus.valid <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_stall = 0;
    end else if (calm) begin
      out_bus.ready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_bus.ready <= 1'b0;
    end else if ($urandom_range(99, 0) < 10) begin
      sink_stall = $urandom_range(12, 0);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      views_seen++;
      if (expected_views.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: char=%h attr=%h col=%0d row=%0d",
                   out_bus.cell_char, out_bus.cell_attr, out_bus.cursor_col, out_bus.cursor_row);
      end else begin
        console_view_t want;
        want = expected_views.pop_front();
        if (out_bus.cell_char !== want.cell_char || out_bus.cell_attr !== want.cell_attr ||
            out_bus.cursor_col !== want.cursor_col || out_bus.cursor_row !== want.cursor_row) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result word %0d: expected char=%h attr=%h col=%0d row=%0d, ",
                     views_seen, want.cell_char, want.cell_attr, want.cursor_col, want.cursor_row,
                     "got char=%h attr=%h col=%0d row=%0d",
                     out_bus.cell_char, out_bus.cell_attr, out_bus.cursor_col, out_bus.cursor_row);
        end
      end
    end
  end

  task automatic queue_word(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx);
    console_word_t w;
    w.op = op;
    w.ch = ch;
    w.idx = idx;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [CHAR_W-1:0] text_byte();
    logic [CHAR_W-1:0] b;
    if ($urandom_range(99, 0) < 85) return CHAR_W'($urandom_range(126, 32));
    do b = CHAR_W'($urandom()); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom());
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (views_seen != words_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attr(input logic [CHAR_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    text_attr = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_session(input int n);
    int target;
    int kind;
    int len;
    logic [OP_W-1:0] op;
    target = words_queued + n;
    while (words_queued < target) begin
      kind = $urandom_range(99, 0);
      if (kind < 40) begin
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(90, 70) : $urandom_range(24, 0);
        repeat (len) queue_word(OP_PUT, text_byte(), any_index());
        if ($urandom_range(3, 0) == 0) queue_word(OP_PUT, CH_CR, any_index());
        queue_word(OP_PUT, CH_LF, any_index());
      end else if (kind < 48) begin
        // A full line wraps on its own, so the newline after it is swallowed.
        repeat (COLS) queue_word(OP_PUT, text_byte(), any_index());
        if ($urandom_range(1, 0) == 0) queue_word(OP_PUT, CH_CR, any_index());
        queue_word(OP_PUT, CH_LF, any_index());
        if ($urandom_range(3, 0) == 0) queue_word(OP_PUT, CH_LF, any_index());
      end else if (kind < 68) begin
        repeat ($urandom_range(4, 1)) begin
          if ($urandom_range(9, 0) < 7)
            queue_word(OP_READ, CHAR_W'($urandom()),
                       IDX_W'($urandom_range(ROWS - 1, 0) * COLS + $urandom_range(31, 0)));
          else
            queue_word(OP_READ, CHAR_W'($urandom()), any_index());
        end
      end else if (kind < 78) begin
        repeat ($urandom_range(4, 1)) queue_word(OP_PUT, CH_LF, any_index());
      end else if (kind < 79) begin
        queue_word(OP_CLEAR, CHAR_W'($urandom()), any_index());
      end else if (kind < 88) begin
        queue_word(OP_READ, CHAR_W'($urandom()), any_index());
        queue_word(OP_PUT, text_byte(), any_index());
      end else begin
        repeat ($urandom_range(3, 1)) begin
          op = OP_W'($urandom_range(3, 0));
          if (op == OP_CLEAR && $urandom_range(7, 0) != 0) op = OP_SPARE;
          queue_word(op, CHAR_W'($urandom()), any_index());
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_bus.valid = 1'b0;
    in_bus.operation = '0;
    in_bus.char_code = '0;
    in_bus.cell_index = '0;
    out_bus.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    queue_word(OP_READ, 8'h00, 11'd0);
    queue_word(OP_PUT, 8'h41, 11'd0);
    queue_word(OP_PUT, 8'hFF, 11'h7FF);
    queue_word(OP_PUT, 8'h00, 11'd0);
    queue_word(OP_PUT, CH_CR, 11'd5);
    queue_word(OP_READ, 8'hFF, 11'd0);
    queue_word(OP_READ, 8'h00, 11'd1);
    queue_word(OP_READ, 8'h00, 11'd2);
    queue_word(OP_PUT, CH_LF, 11'd0);
    queue_word(OP_PUT, CH_CR, 11'd0);
    queue_word(OP_PUT, CH_LF, 11'd0);
    queue_word(OP_PUT, 8'h42, 11'd0);
    queue_word(OP_READ, 8'h00, 11'(2 * COLS));
    queue_word(OP_READ, 8'h00, 11'(CELLS - 1));
    queue_word(OP_READ, 8'h00, 11'(CELLS));
    queue_word(OP_READ, 8'hFF, 11'h7FF);
    queue_word(OP_SPARE, 8'hFF, 11'h7FF);
    queue_word(OP_SPARE, 8'h00, 11'd0);
    queue_word(OP_PUT, CH_LF, 11'd0);
    queue_word(OP_CLEAR, 8'hFF, 11'h7FF);
    queue_word(OP_READ, 8'h00, 11'd0);
    queue_word(OP_PUT, 8'h7E, 11'd0);
    queue_word(OP_CLEAR, 8'h00, 11'd0);
    wait_drained();

    write_attr(8'hFF);
    @(negedge clk);
    queue_session(150);
    wait_drained();
    @(negedge clk);
    queue_session(150);
    wait_drained();

    write_attr(8'h00);
    @(negedge clk);
    queue_session(300);
    wait_drained();

    write_attr(CHAR_W'($urandom()));
    @(negedge clk);
    queue_session(300);
    wait_drained();

    write_attr(8'hA5);
    calm = 1'b1;
    @(negedge clk);
    queue_session(330);
    wait_drained();
    repeat (10) @(posedge clk);

    if (expected_views.size() != 0) mismatch_count++;
    if (mismatch_count == 0)
      $display("tb_text_console_writer_core OK");
    else
      $display("tb_text_console_writer_core NOT OK");
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_text_console_writer_core NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_in_if.sv
hw/rtl/tcw_out_if.sv
hw/rtl/tcw_ram.sv
hw/rtl/tcw_front.sv
hw/rtl/tcw_cmd_fifo.sv
hw/rtl/tcw_back.sv
hw/rtl/text_console_writer_core.sv
hw/rtl/tcw_checker.sv
tb/tb_text_console_writer_core.sv
